/* hw/rtl/light_footprint_strip_builder_unit_assert.svh */
// Assertion macros for the light footprint strip builder.
// Expects clk and rst_n in the scope of use.
`ifndef LIGHT_FOOTPRINT_STRIP_BUILDER_UNIT_ASSERT_SVH
`define LIGHT_FOOTPRINT_STRIP_BUILDER_UNIT_ASSERT_SVH

// same-cycle implication
`define LFSB_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFSB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lfsb_pkg.sv */
// Shared types and constants of the light footprint strip builder.
// No dependencies.
package lfsb_pkg;

    localparam int MAX_COLS_DEF     = 64;
    localparam int MAX_ROWS_DEF     = 64;
    localparam int CELL_SPACING_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT        = 3'd7;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    typedef struct packed {
        logic signed [15:0] h;
        logic [7:0]         alpha;
        logic               outside;
        logic               numbered;
        logic [11:0]        number;
    } lpoint_t;

    localparam int LPOINT_W = $bits(lpoint_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Z,
        ST_DX,
        ST_DY,
        ST_DZ,
        ST_MULA,
        ST_MULB,
        ST_LUM,
        ST_ALPHA,
        ST_EMIT,
        ST_WB0,
        ST_WB1
    } state_t;

endpackage

/* hw/rtl/lfsb_if.sv */
// Stream channels of the light footprint strip builder: samples in, results out.
// No dependencies.
interface lfsb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height;
    logic               in_map;
    modport source (output valid, height, in_map, input ready);
    modport sink (input valid, height, in_map, output ready);
endinterface

interface lfsb_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [11:0]        vertex_number;
    logic [5:0]         column;
    logic [5:0]         row;
    logic signed [15:0] vertex_height;
    logic [7:0]         alpha;
    logic               last;
    modport source (output valid, kind, vertex_number, column, row, vertex_height, alpha,
                    last, input ready);
    modport sink (input valid, kind, vertex_number, column, row, vertex_height, alpha,
                  last, output ready);
endinterface

/* hw/rtl/lfsb_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lfsb_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/light_footprint_strip_builder_unit.sv */
// Channel   | Dir | Beat contents
// samples   | in  | height, in_map: one grid sample, row-major
// results   | out | kind, vertex_number, column, row, vertex_height, alpha, last
// cfg       | in  | cfg_we, cfg_index, cfg_data: register write, no read-back
// One sample at a time: serial setup (accept, two line-buffer reads, squarer
// shared over dx, dy and dz, two 16-bit slice multiplies), then the
// emission slots (6 on an open strip, 10 on a strip restart, 0 for an edge sample
// or a skipped quad), then write-back in ST_WB0 and ST_WB1.
// A new sample is taken only once the previous one is written back;
// a stalled result port holds the emission sequencer.
// No clearing pass: line-buffer contents are undefined until written.
// Top level; depends on lfsb_pkg, lfsb_if, lfsb_ram and the assertion header.
`include "light_footprint_strip_builder_unit_assert.svh"
module light_footprint_strip_builder_unit
    import lfsb_pkg::*;
#(
    parameter int MAX_COLS     = MAX_COLS_DEF,
    parameter int MAX_ROWS     = MAX_ROWS_DEF,
    parameter int CELL_SPACING = CELL_SPACING_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lfsb_in_if.sink               samples,
    lfsb_out_if.source            results
);
    localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int PW      = $clog2(MAX_DIM * CELL_SPACING) + 1;
    localparam int DW      = ((PW > 16) ? PW : 16) + 1;
    localparam int SW      = 2 * DW + 2;
    localparam int AXW     = SW + 16;
    localparam int PXW     = SW + 33;
    localparam int NW      = 9;

    localparam logic [3:0] EM_V_BL = 4'd0;
    localparam logic [3:0] EM_V_TL = 4'd1;
    localparam logic [3:0] EM_V_BR = 4'd2;
    localparam logic [3:0] EM_V_TR = 4'd3;
    localparam logic [3:0] EM_I_0  = 4'd4;
    localparam logic [3:0] EM_I_1  = 4'd5;
    localparam logic [3:0] EM_I_2  = 4'd6;
    localparam logic [3:0] EM_I_3  = 4'd7;
    localparam logic [3:0] EM_I_4  = 4'd8;
    localparam logic [3:0] EM_I_5  = 4'd9;

    // configuration
    logic signed [15:0] light_x_reg, light_y_reg, light_z_reg, floor_level_reg, lift_reg;
    logic [31:0]        inv_radius_sq_reg;
    logic [6:0]         grid_cols_reg, grid_rows_reg;

    // control state
    state_t            state_reg, state_next;
    logic [AW-1:0]     col_reg;
    logic [RW-1:0]     row_reg;
    logic [12:0]       next_number_reg;
    logic              strip_open_reg, any_index_reg;
    logic [11:0]       last_index_reg;
    lpoint_t           lp_reg;
    logic [3:0]        step_reg;
    logic              ov_reg;

    // datapath
    logic signed [15:0] z_reg;
    logic [SW-1:0]      s_reg;
    logic [AXW-1:0]     a_reg, b_reg;
    logic [32:0]        p_reg;
    logic               outside_reg, skip_reg;
    lpoint_t            tl_reg, tr_reg, np_reg;

    logic               o_kind_reg, o_last_reg;
    logic [11:0]        o_num_reg;
    logic [5:0]         o_col_reg, o_row_reg;
    logic signed [15:0] o_h_reg;
    logic [7:0]         o_alpha_reg;

    // RAM
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [LPOINT_W-1:0] ram_wdata, ram_rdata;

    lfsb_ram #(
        .WIDTH (LPOINT_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [5:0] pos6(input logic [31:0] v);
        return v[5:0];
    endfunction

    // grid bookkeeping
    logic [NW-1:0] cols_raw, rows_raw, cols_eff, rows_eff;
    logic          last_col, last_row, quad;

    assign cols_raw = NW'(grid_cols_reg);
    assign rows_raw = NW'(grid_rows_reg);
    assign cols_eff = (cols_raw < NW'(2)) ? NW'(2) :
                      (cols_raw > NW'(MAX_COLS)) ? NW'(MAX_COLS) : cols_raw;
    assign rows_eff = (rows_raw < NW'(2)) ? NW'(2) :
                      (rows_raw > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : rows_raw;
    assign last_col = NW'(col_reg) >= (cols_eff - NW'(1));
    assign last_row = NW'(row_reg) >= (rows_eff - NW'(1));
    assign quad     = (col_reg != '0) && (row_reg != '0);

    // lifted, floored, saturated height
    logic signed [16:0] hl, flr17, zsel;
    logic signed [15:0] z_next;

    assign hl     = 17'(samples.height) + 17'(lift_reg);
    assign flr17  = 17'(floor_level_reg);
    assign zsel   = samples.in_map ? ((hl < flr17) ? flr17 : hl) : flr17;
    assign z_next = (zsel > 17'sd32767) ? 16'sh7FFF : zsel[15:0];

    // shared squarer
    logic [PW-1:0]        pos_c, pos_r;
    logic signed [DW-1:0] dx, dy, dz, dsel;
    logic [DW-1:0]        mag;
    logic [2*DW-1:0]      sq;

    assign pos_c = PW'(col_reg) * PW'(CELL_SPACING);
    assign pos_r = PW'(row_reg) * PW'(CELL_SPACING);
    assign dx    = DW'(light_x_reg) - $signed(DW'({1'b0, pos_c}));
    assign dy    = DW'(light_y_reg) - $signed(DW'({1'b0, pos_r}));
    assign dz    = DW'(light_z_reg) - DW'(z_reg);

    always_comb
    begin
        case (state_reg)
            ST_DX:   dsel = dx;
            ST_DY:   dsel = dy;
            default: dsel = dz;
        endcase
    end

    assign mag = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
    assign sq  = mag * mag;

    // light term
    logic [PXW-1:0] p_ext;
    logic [32:0]    diff;
    logic [41:0]    aprod;
    logic [7:0]     alpha_val;

    assign p_ext     = (PXW'(a_reg) << 16) + PXW'(b_reg);
    assign diff      = 33'h1_0000_0000 - p_reg;
    assign aprod     = 42'(diff) * 42'd255 + 42'h0_8000_0000;
    assign alpha_val = outside_reg ? 8'd0 : aprod[39:32];

    // emission sequencer
    lpoint_t            em_pt;
    logic               em_want, em_vert, em_done, em_load, em_adv, slot_free;
    logic [11:0]        em_num;
    logic [5:0]         em_col, em_row;

    assign slot_free = !ov_reg || results.ready;

    always_comb
    begin
        em_vert = 1'b0;
        em_want = 1'b0;
        em_num  = 12'd0;
        em_col  = 6'd0;
        em_row  = 6'd0;
        em_pt   = lp_reg;
        em_done = 1'b0;
        case (step_reg)
            EM_V_BL:
            begin
                em_vert = 1'b1;
                em_pt   = lp_reg;
                em_col  = pos6(32'(col_reg - 1'b1));
                em_row  = pos6(32'(row_reg));
            end
            EM_V_TL:
            begin
                em_vert = 1'b1;
                em_pt   = tl_reg;
                em_col  = pos6(32'(col_reg - 1'b1));
                em_row  = pos6(32'(row_reg - 1'b1));
            end
            EM_V_BR:
            begin
                em_vert = 1'b1;
                em_pt   = np_reg;
                em_col  = pos6(32'(col_reg));
                em_row  = pos6(32'(row_reg));
            end
            EM_V_TR:
            begin
                em_vert = 1'b1;
                em_pt   = tr_reg;
                em_col  = pos6(32'(col_reg));
                em_row  = pos6(32'(row_reg - 1'b1));
            end
            EM_I_0:
            begin
                em_want = strip_open_reg || any_index_reg;
                em_num  = strip_open_reg ? np_reg.number : last_index_reg;
            end
            EM_I_1:
            begin
                em_want = strip_open_reg || any_index_reg;
                em_num  = strip_open_reg ? tr_reg.number : lp_reg.number;
                em_done = strip_open_reg;
            end
            EM_I_2:
            begin
                em_want = 1'b1;
                em_num  = lp_reg.number;
            end
            EM_I_3:
            begin
                em_want = 1'b1;
                em_num  = tl_reg.number;
            end
            EM_I_4:
            begin
                em_want = 1'b1;
                em_num  = np_reg.number;
            end
            EM_I_5:
            begin
                em_want = 1'b1;
                em_num  = tr_reg.number;
                em_done = 1'b1;
            end
            default:
            begin
                em_done = 1'b1;
            end
        endcase
        if (em_vert)
        begin
            em_want = !em_pt.numbered;
            em_num  = next_number_reg[11:0];
        end
    end

    assign em_adv  = (state_reg == ST_EMIT) && (!em_want || slot_free);
    assign em_load = em_adv && em_want;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (samples.valid) state_next = ST_Z;
            ST_Z:     state_next = ST_DX;
            ST_DX:    state_next = ST_DY;
            ST_DY:    state_next = ST_DZ;
            ST_DZ:    state_next = ST_MULA;
            ST_MULA:  state_next = ST_MULB;
            ST_MULB:  state_next = ST_LUM;
            ST_LUM:   state_next = ST_ALPHA;
            ST_ALPHA: state_next = (quad && !(tl_reg.outside && tr_reg.outside &&
                                   lp_reg.outside && outside_reg)) ? ST_EMIT : ST_WB0;
            ST_EMIT:  if (em_adv && em_done) state_next = ST_WB0;
            ST_WB0:   state_next = ST_WB1;
            ST_WB1:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        samples.ready = 1'b0;
        ram_raddr     = col_reg;
        ram_we        = 1'b0;
        ram_waddr     = col_reg;
        ram_wdata     = tr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                ram_raddr     = col_reg - 1'b1;
            end
            ST_WB0:
            begin
                ram_we    = (col_reg != '0);
                ram_waddr = col_reg - 1'b1;
                ram_wdata = lp_reg;
            end
            ST_WB1:
            begin
                ram_we    = quad || last_col;
                ram_wdata = last_col ? np_reg : tr_reg;
            end
            default:
            begin
                ram_raddr = col_reg;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg       <= '0;
            light_y_reg       <= '0;
            light_z_reg       <= '0;
            inv_radius_sq_reg <= '0;
            grid_cols_reg     <= 7'd2;
            grid_rows_reg     <= 7'd2;
            floor_level_reg   <= '0;
            lift_reg          <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIGHT_X:     light_x_reg       <= cfg_data[15:0];
                CFG_LIGHT_Y:     light_y_reg       <= cfg_data[15:0];
                CFG_LIGHT_Z:     light_z_reg       <= cfg_data[15:0];
                CFG_INV_RADIUS:  inv_radius_sq_reg <= cfg_data[31:0];
                CFG_GRID_COLS:   grid_cols_reg     <= cfg_data[6:0];
                CFG_GRID_ROWS:   grid_rows_reg     <= cfg_data[6:0];
                CFG_FLOOR_LEVEL: floor_level_reg   <= cfg_data[15:0];
                CFG_LIFT:        lift_reg          <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            row_reg         <= '0;
            next_number_reg <= '0;
            strip_open_reg  <= 1'b0;
            any_index_reg   <= 1'b0;
            last_index_reg  <= '0;
            lp_reg          <= '0;
            step_reg        <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (em_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                ov_reg <= 1'b0;
            end

            if (state_reg == ST_ALPHA)
            begin
                step_reg <= EM_V_BL;
            end
            else if (em_adv)
            begin
                step_reg <= step_reg + 4'd1;
            end

            if (em_load && em_vert)
            begin
                next_number_reg <= next_number_reg + 13'd1;
                if (step_reg == EM_V_BL)
                begin
                    lp_reg.numbered <= 1'b1;
                    lp_reg.number   <= em_num;
                end
            end
            if (em_load && !em_vert)
            begin
                last_index_reg <= em_num;
                any_index_reg  <= 1'b1;
            end
            if (em_adv && em_done && !strip_open_reg)
            begin
                strip_open_reg <= 1'b1;
            end

            if (state_reg == ST_WB1)
            begin
                lp_reg <= np_reg;
                // skipped quad or row end closes the strip
                if ((quad && skip_reg) || last_col)
                begin
                    strip_open_reg <= 1'b0;
                end
                if (last_col)
                begin
                    col_reg <= '0;
                    if (last_row)
                    begin
                        row_reg         <= '0;
                        next_number_reg <= '0;
                        any_index_reg   <= 1'b0;
                    end
                    else
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:  z_reg <= z_next;
            ST_Z:     tl_reg <= ram_rdata;
            ST_DX:
            begin
                tr_reg <= ram_rdata;
                s_reg  <= SW'(sq);
            end
            ST_DY:    s_reg <= s_reg + SW'(sq);
            ST_DZ:    s_reg <= s_reg + SW'(sq);
            ST_MULA:  a_reg <= AXW'(s_reg) * AXW'(inv_radius_sq_reg[31:16]);
            ST_MULB:  b_reg <= AXW'(s_reg) * AXW'(inv_radius_sq_reg[15:0]);
            ST_LUM:
            begin
                outside_reg <= (a_reg > AXW'(65536)) || (p_ext > PXW'(64'h1_0000_0000));
                p_reg       <= p_ext[32:0];
            end
            ST_ALPHA:
            begin
                np_reg.h        <= z_reg;
                np_reg.alpha    <= alpha_val;
                np_reg.outside  <= outside_reg;
                np_reg.numbered <= 1'b0;
                np_reg.number   <= '0;
                skip_reg        <= tl_reg.outside && tr_reg.outside &&
                                   lp_reg.outside && outside_reg;
            end
            ST_EMIT:
            begin
                if (em_load && em_vert)
                begin
                    case (step_reg)
                        EM_V_TL:
                        begin
                            tl_reg.numbered <= 1'b1;
                            tl_reg.number   <= em_num;
                        end
                        EM_V_BR:
                        begin
                            np_reg.numbered <= 1'b1;
                            np_reg.number   <= em_num;
                        end
                        EM_V_TR:
                        begin
                            tr_reg.numbered <= 1'b1;
                            tr_reg.number   <= em_num;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        if (em_load)
        begin
            o_kind_reg  <= em_vert ? KIND_VERTEX : KIND_INDEX;
            o_num_reg   <= em_num;
            o_col_reg   <= em_vert ? em_col : 6'd0;
            o_row_reg   <= em_vert ? em_row : 6'd0;
            o_h_reg     <= em_vert ? em_pt.h : 16'sd0;
            o_alpha_reg <= em_vert ? em_pt.alpha : 8'd0;
            o_last_reg  <= em_done;
        end
    end

    assign results.valid         = ov_reg;
    assign results.kind          = o_kind_reg;
    assign results.vertex_number = o_num_reg;
    assign results.column        = o_col_reg;
    assign results.row           = o_row_reg;
    assign results.vertex_height = o_h_reg;
    assign results.alpha         = o_alpha_reg;
    assign results.last          = o_last_reg;

    `LFSB_ASSERT_NEXT(a_busy, samples.valid && samples.ready, state_reg != ST_IDLE, "idle after accept")
    `LFSB_ASSERT_NEXT(a_hold, ov_reg && !results.ready, ov_reg && $stable(o_num_reg), "beat lost")
    `LFSB_ASSERT_IMPL(a_ram_wb, ram_we, state_reg == ST_WB0 || state_reg == ST_WB1, "stray write")
    `LFSB_ASSERT_IMPL(a_no_overwrite, em_load && results.valid, results.ready, "beat overwritten")

endmodule

/* test/light_footprint_strip_builder_unit_tb.sv */
// Self-checking bench for the light footprint strip builder: drives grids of
// terrain samples, predicts vertex and strip-index beats, compares them in order.
// Depends on lfsb_pkg, lfsb_if and the top level light_footprint_strip_builder_unit.
`timescale 1ns / 1ps

module light_footprint_strip_builder_unit_tb;
    import lfsb_pkg::*;

    typedef struct {
        logic signed [15:0] height;
        logic               in_map;
    } sample_t;

    typedef struct {
        logic               kind;
        logic [11:0]        vertex_number;
        logic [5:0]         column;
        logic [5:0]         row;
        logic signed [15:0] vertex_height;
        logic [7:0]         alpha;
        logic               last;
    } emit_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lfsb_in_if  samples ();
    lfsb_out_if results ();

    light_footprint_strip_builder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (samples.sink),
        .results  (results.source)
    );

    always #5 clk = ~clk;

    initial
    begin
        samples.valid  = 1'b0;
        samples.height = '0;
        samples.in_map = 1'b0;
        results.ready  = 1'b0;
    end

    // register shadow
    logic signed [15:0] light_x_r, light_y_r, light_z_r, floor_r, lift_r;
    logic [31:0]        inv_rsq_r;
    logic [6:0]         cols_r, rows_r;

    // line buffer and walk position
    lpoint_t     line_buf [64];
    lpoint_t     left_pt;
    logic [12:0] next_num;
    bit          strip_open, any_index;
    logic [11:0] last_index;
    int          cur_col, cur_row;

    sample_t pending_samples [$];
    emit_t   expected_beats [$];
    emit_t   step_beats [$];

    int  errors = 0;
    int  sent_count = 0;
    longint cycles = 0;

    task automatic push_beat(input logic kind, input logic [11:0] num, input int col,
                             input int row, input logic signed [15:0] h, input logic [7:0] al);
        emit_t e;
        e.kind = kind;
        e.vertex_number = num;
        e.column = col[5:0];
        e.row = row[5:0];
        e.vertex_height = h;
        e.alpha = al;
        e.last = 1'b0;
        step_beats.insert(step_beats.size(), e);
    endtask

    task automatic number_corner(inout lpoint_t pt, input int col, input int row);
        if (!pt.numbered)
        begin
            pt.numbered = 1'b1;
            pt.number = next_num[11:0];
            next_num = next_num + 13'd1;
            push_beat(KIND_VERTEX, pt.number, col, row, pt.h, pt.alpha);
        end
    endtask

    task automatic push_index(input logic [11:0] v);
        push_beat(KIND_INDEX, v, 0, 0, 16'sd0, 8'd0);
        last_index = v;
        any_index = 1'b1;
    endtask

    task automatic strip_predict(input logic signed [15:0] height, input logic in_map);
        int cols, rows, c, r;
        longint z, flr, dx, dy, dz;
        longint unsigned s, a, b, p;
        bit last_col, outs;
        logic [7:0] al;
        lpoint_t np, tl, tr;
        cols = cols_r;
        rows = rows_r;
        if (cols < 2) cols = 2;
        if (cols > 64) cols = 64;
        if (rows < 2) rows = 2;
        if (rows > 64) rows = 64;
        c = cur_col;
        r = cur_row;
        if (c >= 64) c = 63;
        last_col = c >= cols - 1;
        flr = floor_r;
        if (in_map)
        begin
            z = longint'(height) + longint'(lift_r);
            if (z < flr) z = flr;
        end
        else
            z = flr;
        if (z > 32767) z = 32767;
        if (z < -32768) z = -32768;
        dx = longint'(light_x_r) - c * 16;
        dy = longint'(light_y_r) - r * 16;
        dz = longint'(light_z_r) - z;
        s = dx * dx + dy * dy + dz * dz;
        a = s * longint'(inv_rsq_r[31:16]);
        b = s * longint'(inv_rsq_r[15:0]);
        al = 8'd0;
        if (a > 65536)
            outs = 1'b1;
        else
        begin
            p = (a << 16) + b;
            outs = p > (64'd1 << 32);
            if (!outs)
                al = 8'((((64'd1 << 32) - p) * 255 + (64'd1 << 31)) >> 32);
        end
        np.h = 16'(z);
        np.alpha = al;
        np.outside = outs;
        np.numbered = 1'b0;
        np.number = '0;
        step_beats.delete();
        if (c > 0 && r > 0)
        begin
            tl = line_buf[c - 1];
            tr = line_buf[c];
            if (tl.outside && tr.outside && left_pt.outside && np.outside)
                strip_open = 1'b0;
            else
            begin
                number_corner(left_pt, c - 1, r);
                number_corner(tl, c - 1, r - 1);
                number_corner(np, c, r);
                number_corner(tr, c, r - 1);
                if (strip_open)
                begin
                    push_index(np.number);
                    push_index(tr.number);
                end
                else
                begin
                    // degenerate join when restarting a strip
                    if (any_index)
                    begin
                        push_index(last_index);
                        push_index(left_pt.number);
                    end
                    push_index(left_pt.number);
                    push_index(tl.number);
                    push_index(np.number);
                    push_index(tr.number);
                    strip_open = 1'b1;
                end
            end
            line_buf[c] = tr;
        end
        if (c > 0) line_buf[c - 1] = left_pt;
        left_pt = np;
        if (last_col)
        begin
            line_buf[c] = np;
            strip_open = 1'b0;
            cur_col = 0;
            if (r >= rows - 1)
            begin
                cur_row = 0;
                next_num = '0;
                any_index = 1'b0;
            end
            else
                cur_row = (r + 1) & 63;
        end
        else
            cur_col = (c + 1) & 63;
        if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            samples.valid <= 1'b0;
        else
        begin
            if (samples.valid && samples.ready)
                strip_predict(samples.height, samples.in_map);
            if (!samples.valid || samples.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    samples.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_t sm;
                    sm = pending_samples.pop_front();
                    samples.valid <= 1'b1;
                    samples.height <= sm.height;
                    samples.in_map <= sm.in_map;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
                else
                    samples.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern in one of four randomly chosen modes
    int ready_mode = 0;
    int ready_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            ready_cnt = ready_cnt + 1;
            if (ready_cnt % 64 == 0) ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0: results.ready <= 1'b1;
                1: results.ready <= (ready_cnt % 7) < 4;
                2: results.ready <= ($urandom_range(0, 3) != 0);
                default: results.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= 10) $display("unexpected beat kind=%0d num=%0d",
                                           results.kind, results.vertex_number);
            end
            else
            begin
                emit_t e;
                e = expected_beats.pop_front();
                if (results.kind !== e.kind || results.vertex_number !== e.vertex_number
                    || results.column !== e.column || results.row !== e.row
                    || results.vertex_height !== e.vertex_height
                    || results.alpha !== e.alpha || results.last !== e.last)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("beat mismatch exp k=%0d n=%0d c=%0d r=%0d h=%0d a=%0d l=%0d",
                                 e.kind, e.vertex_number, e.column, e.row, e.vertex_height,
                                 e.alpha, e.last, " got k=%0d n=%0d c=%0d r=%0d h=%0d a=%0d l=%0d",
                                 results.kind, results.vertex_number, results.column,
                                 results.row, results.vertex_height, results.alpha,
                                 results.last);
                end
            end
        end
        if (cycles > 3000000)
        begin
            $display("light_footprint_strip_builder_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LIGHT_X:     light_x_r = val[15:0];
            CFG_LIGHT_Y:     light_y_r = val[15:0];
            CFG_LIGHT_Z:     light_z_r = val[15:0];
            CFG_INV_RADIUS:  inv_rsq_r = val;
            CFG_GRID_COLS:   cols_r = val[6:0];
            CFG_GRID_ROWS:   rows_r = val[6:0];
            CFG_FLOOR_LEVEL: floor_r = val[15:0];
            CFG_LIFT:        lift_r = val[15:0];
            default:         ;
        endcase
    endtask

    task automatic write_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_samples.size() > 0 || samples.valid || expected_beats.size() > 0)
            @(posedge clk);
        // a skipped quad emits nothing; let the last sample drain
        repeat (40) @(posedge clk);
    endtask

    function automatic int eff_size(input logic [6:0] v);
        if (v < 2) return 2;
        if (v > 64) return 64;
        return v;
    endfunction

    task automatic add_sample(input logic signed [15:0] h, input logic m);
        sample_t sm;
        sm.height = h;
        sm.in_map = m;
        pending_samples.insert(pending_samples.size(), sm);
        sent_count = sent_count + 1;
    endtask

    task automatic random_grid(input int wide);
        int n;
        n = eff_size(cols_r) * eff_size(rows_r);
        for (int i = 0; i < n; i++)
        begin
            if (wide || $urandom_range(0, 7) == 0)
                add_sample(16'($urandom), 1'($urandom));
            else
                add_sample(16'($urandom_range(0, 120)) - 16'sd60,
                           $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic random_setup(input int cols, input int rows);
        int rad;
        rad = $urandom_range(8, 120);
        write_reg(CFG_GRID_COLS, cols);
        write_reg(CFG_GRID_ROWS, rows);
        if ($urandom_range(0, 5) == 0)
        begin
            write_reg(CFG_LIGHT_X, $urandom);
            write_reg(CFG_LIGHT_Y, $urandom);
            write_reg(CFG_LIGHT_Z, $urandom);
        end
        else
        begin
            write_reg(CFG_LIGHT_X, $urandom_range(0, eff_size(7'(cols)) * 16));
            write_reg(CFG_LIGHT_Y, $urandom_range(0, eff_size(7'(rows)) * 16));
            write_reg(CFG_LIGHT_Z, $urandom_range(0, 80));
        end
        case ($urandom_range(0, 9))
            0: write_reg(CFG_INV_RADIUS, 32'd0);
            1: write_reg(CFG_INV_RADIUS, 32'hFFFF_FFFF);
            2: write_reg(CFG_INV_RADIUS, $urandom);
            default: write_reg(CFG_INV_RADIUS, 32'((64'd1 << 32) / (rad * rad)));
        endcase
        write_reg(CFG_FLOOR_LEVEL, 32'($urandom_range(0, 40)) - 32'd20);
        write_reg(CFG_LIFT, 32'($urandom_range(0, 40)) - 32'd20);
        write_done();
    endtask

    initial
    begin
        light_x_r = 0; light_y_r = 0; light_z_r = 0; floor_r = 0; lift_r = 0;
        inv_rsq_r = 0; cols_r = 2; rows_r = 2;
        foreach (line_buf[i]) line_buf[i] = '0;
        left_pt = '0;
        next_num = '0;
        strip_open = 1'b0;
        any_index = 1'b0;
        last_index = '0;
        cur_col = 0;
        cur_row = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: everything inside, height extremes and off-map point
        add_sample(16'sh7FFF, 1'b1);
        add_sample(-16'sh8000, 1'b1);
        add_sample(16'sd0, 1'b0);
        add_sample(16'sd1, 1'b1);
        wait_idle();

        // far light, tiny radius: all-outside quad is skipped
        write_reg(CFG_LIGHT_X, 32'h7FFF);
        write_reg(CFG_LIGHT_Y, 32'h7FFF);
        write_reg(CFG_LIGHT_Z, 32'h7FFF);
        write_reg(CFG_INV_RADIUS, 32'hFFFF_FFFF);
        write_reg(CFG_LIFT, 32'h7FFF);
        write_reg(CFG_FLOOR_LEVEL, 32'hFFFF_8000);
        write_done();
        add_sample(16'sh7FFF, 1'b1);
        add_sample(16'sh7FFF, 1'b1);
        add_sample(-16'sh8000, 1'b0);
        add_sample(16'sd5, 1'b1);
        wait_idle();

        // lowest light, lift low and floor high, 3x3 with raw size codes
        write_reg(CFG_LIGHT_X, 32'h8000);
        write_reg(CFG_LIGHT_Y, 32'h8000);
        write_reg(CFG_LIGHT_Z, 32'h8000);
        write_reg(CFG_INV_RADIUS, 32'd1);
        write_reg(CFG_LIFT, 32'h8000);
        write_reg(CFG_FLOOR_LEVEL, 32'h7FFF);
        write_reg(CFG_GRID_COLS, 32'd3);
        write_reg(CFG_GRID_ROWS, 32'd3);
        write_done();
        for (int i = 0; i < 9; i++) add_sample(16'($urandom), i[0]);
        wait_idle();

        // widest and tallest grids, size codes out of range
        random_setup(127, 2);
        random_grid(0);
        wait_idle();
        random_setup(0, 64);
        random_grid(0);
        wait_idle();

        while (sent_count < 300)
        begin
            random_setup($urandom_range(2, 7), $urandom_range(2, 6));
            random_grid($urandom_range(0, 4) == 0);
            wait_idle();
        end

        if (errors == 0)
            $display("light_footprint_strip_builder_unit: match");
        else
            $display("light_footprint_strip_builder_unit: mismatch");
        $finish;
    end

endmodule

/* light_footprint_strip_builder_unit.f */
+incdir+hw/rtl
hw/rtl/lfsb_pkg.sv
hw/rtl/lfsb_if.sv
hw/rtl/lfsb_ram.sv
hw/rtl/light_footprint_strip_builder_unit.sv
test/light_footprint_strip_builder_unit_tb.sv
